[rtl/core/whsp_pkg.sv]
// types and constants shared by the wav header stream parser
package whsp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  parse_status;
    logic        float_format;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
  } out_t;

  typedef enum logic [13:0] {
    PH_RIFF_TAG   = 14'b00000000000001,
    PH_RIFF_LEN   = 14'b00000000000010,
    PH_WAVE_TAG   = 14'b00000000000100,
    PH_FMT_TAG    = 14'b00000000001000,
    PH_FMT_SIZE   = 14'b00000000010000,
    PH_FMT_FORMAT = 14'b00000000100000,
    PH_FMT_CHAN   = 14'b00000001000000,
    PH_FMT_RATE   = 14'b00000010000000,
    PH_FMT_BRATE  = 14'b00000100000000,
    PH_FMT_ALIGN  = 14'b00001000000000,
    PH_FMT_BITS   = 14'b00010000000000,
    PH_CHUNK_TAG  = 14'b00100000000000,
    PH_CHUNK_LEN  = 14'b01000000000000,
    PH_BODY       = 14'b10000000000000
  } phase_t;

  localparam logic [2:0] ST_PARSING = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_BAD_TAG = 3'd2;
  localparam logic [2:0] ST_CORRUPT = 3'd3;
  localparam logic [2:0] ST_UNSUPP  = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;

  // tags as they assemble least significant byte first
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] HALF_MASK = 32'h0000_ffff;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] BITS_PCM  = 16'd8;
  localparam logic [15:0] BITS_FLT  = 16'd32;

endpackage

[rtl/core/wav_header_stream_parser.sv]
// wav header stream parser: riff/fmt checks and data chunk byte extraction
//
// Input channel in_*: one file byte per word, least significant byte first
// in every multi-byte field, end_of_file set on the final byte of the file.
// Output channel out_*: exactly one result word per input word, in order.
// A result carries the audio byte (payload_valid set inside a data chunk
// body), the running parse status and the format fields parsed so far.
// The result is registered; throughput is one word per clock while out_ready
// is high, and input stalls once the skid register below is occupied.
// Once parse_status leaves parsing it is sticky: later bytes are consumed
// and answered with the same status and no payload until reset.
// Reset (rst_n low at a clock edge) returns the parser to the riff tag,
// clears all format fields and empties the output stages.
// The result register is backed by a one-word skid register, so one more
// word is taken while out_ready is low; in_ready is registered and falls
// only once the skid register is occupied, and rises again the cycle
// after the receiver drains it.
module wav_header_stream_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  whsp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output whsp_pkg::out_t  out_data
);

  whsp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] brem_r, brem_nxt;
  logic        is_data_r, is_data_nxt;
  logic        float_r, float_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [2:0]  status_r, status_nxt;

  whsp_pkg::out_t out_r, skid_r, res;
  logic out_vld_r, skid_vld_r;

  logic        in_fire, out_fire;
  logic [31:0] acc_w;
  logic        two_byte, last_byte;

  assign in_ready  = !skid_vld_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_fire  = out_vld_r && out_ready;
  assign out_data  = out_r;

  // next field accumulator with the current byte merged in
  always_comb begin
    acc_w = acc_r;
    case (bif_r)
      2'd0:    acc_w[7:0]   = in_data.file_byte;
      2'd1:    acc_w[15:8]  = in_data.file_byte;
      2'd2:    acc_w[23:16] = in_data.file_byte;
      default: acc_w[31:24] = in_data.file_byte;
    endcase
  end

  assign two_byte = (phase_r == whsp_pkg::PH_FMT_FORMAT) ||
                    (phase_r == whsp_pkg::PH_FMT_CHAN) ||
                    (phase_r == whsp_pkg::PH_FMT_ALIGN) ||
                    (phase_r == whsp_pkg::PH_FMT_BITS);
  assign last_byte = two_byte ? bif_r[0] : (bif_r == 2'd3);

  always_comb begin
    phase_nxt   = phase_r;
    bif_nxt     = bif_r;
    acc_nxt     = acc_r;
    total_nxt   = total_r;
    brem_nxt    = brem_r;
    is_data_nxt = is_data_r;
    float_nxt   = float_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    status_nxt  = status_r;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'd0;

    if (status_r == whsp_pkg::ST_PARSING) begin
      if (phase_r == whsp_pkg::PH_BODY) begin
        if (is_data_r) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = in_data.file_byte;
        end
        brem_nxt = brem_r - 32'd1;
        if (brem_r == 32'd1) begin
          phase_nxt = whsp_pkg::PH_CHUNK_TAG;
        end
      end else if (!last_byte) begin
        bif_nxt = bif_r + 2'd1;
        acc_nxt = acc_w;
      end else begin
        bif_nxt = 2'd0;
        acc_nxt = 32'd0;
        unique case (phase_r)
          whsp_pkg::PH_RIFF_TAG: begin
            if (acc_w != whsp_pkg::TAG_RIFF) status_nxt = whsp_pkg::ST_BAD_TAG;
            phase_nxt = whsp_pkg::PH_RIFF_LEN;
          end
          whsp_pkg::PH_RIFF_LEN: begin
            total_nxt = acc_w;
            phase_nxt = whsp_pkg::PH_WAVE_TAG;
          end
          whsp_pkg::PH_WAVE_TAG: begin
            if (acc_w != whsp_pkg::TAG_WAVE) status_nxt = whsp_pkg::ST_BAD_TAG;
            phase_nxt = whsp_pkg::PH_FMT_TAG;
          end
          whsp_pkg::PH_FMT_TAG: begin
            if (acc_w != whsp_pkg::TAG_FMT) status_nxt = whsp_pkg::ST_BAD_TAG;
            phase_nxt = whsp_pkg::PH_FMT_SIZE;
          end
          whsp_pkg::PH_FMT_SIZE: begin
            if (total_r < acc_w) status_nxt = whsp_pkg::ST_CORRUPT;
            phase_nxt = whsp_pkg::PH_FMT_FORMAT;
          end
          whsp_pkg::PH_FMT_FORMAT: begin
            if (acc_w[15:0] == whsp_pkg::FMT_PCM) begin
              float_nxt = 1'b0;
            end else if (acc_w[15:0] == whsp_pkg::FMT_FLOAT) begin
              float_nxt = 1'b1;
            end else begin
              status_nxt = whsp_pkg::ST_UNSUPP;
            end
            phase_nxt = whsp_pkg::PH_FMT_CHAN;
          end
          whsp_pkg::PH_FMT_CHAN: begin
            if (acc_w[15:0] != 16'd1) status_nxt = whsp_pkg::ST_UNSUPP;
            phase_nxt = whsp_pkg::PH_FMT_RATE;
          end
          whsp_pkg::PH_FMT_RATE: begin
            rate_nxt  = acc_w;
            phase_nxt = whsp_pkg::PH_FMT_BRATE;
          end
          whsp_pkg::PH_FMT_BRATE: begin
            phase_nxt = whsp_pkg::PH_FMT_ALIGN;
          end
          whsp_pkg::PH_FMT_ALIGN: begin
            phase_nxt = whsp_pkg::PH_FMT_BITS;
          end
          whsp_pkg::PH_FMT_BITS: begin
            bits_nxt = acc_w[15:0] & whsp_pkg::HALF_MASK[15:0];
            // only 8-bit pcm and 32-bit float pass
            if (!((!float_r && acc_w[15:0] == whsp_pkg::BITS_PCM) ||
                  (float_r && acc_w[15:0] == whsp_pkg::BITS_FLT))) begin
              status_nxt = whsp_pkg::ST_UNSUPP;
            end
            phase_nxt = whsp_pkg::PH_CHUNK_TAG;
          end
          whsp_pkg::PH_CHUNK_LEN: begin
            if (is_data_r && acc_w >= total_r) begin
              status_nxt = whsp_pkg::ST_CORRUPT;
            end else if (acc_w == 32'd0) begin
              phase_nxt = whsp_pkg::PH_CHUNK_TAG;
            end else begin
              brem_nxt  = acc_w;
              phase_nxt = whsp_pkg::PH_BODY;
            end
          end
          default: begin
            is_data_nxt = (acc_w == whsp_pkg::TAG_DATA);
            phase_nxt   = whsp_pkg::PH_CHUNK_LEN;
          end
        endcase
      end

      // end of file decision, an error on the same byte wins
      if (status_nxt == whsp_pkg::ST_PARSING && in_data.end_of_file) begin
        if (phase_nxt == whsp_pkg::PH_CHUNK_TAG && bif_nxt == 2'd0) begin
          status_nxt = whsp_pkg::ST_OK;
        end else if (phase_nxt == whsp_pkg::PH_BODY && !is_data_nxt) begin
          status_nxt = whsp_pkg::ST_OK;
        end else begin
          status_nxt = whsp_pkg::ST_TRUNC;
        end
      end
    end

    res.parse_status = status_nxt;
    res.float_format = float_nxt;
    res.rate_hz      = rate_nxt;
    res.sample_bits  = bits_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= whsp_pkg::PH_RIFF_TAG;
      bif_r     <= 2'd0;
      acc_r     <= 32'd0;
      total_r   <= 32'd0;
      brem_r    <= 32'd0;
      is_data_r <= 1'b0;
      float_r   <= 1'b0;
      rate_r    <= 32'd0;
      bits_r    <= 16'd0;
      status_r  <= whsp_pkg::ST_PARSING;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      bif_r     <= bif_nxt;
      acc_r     <= acc_nxt;
      total_r   <= total_nxt;
      brem_r    <= brem_nxt;
      is_data_r <= is_data_nxt;
      float_r   <= float_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      status_r  <= status_nxt;
    end
  end

  // result register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_vld_r || out_fire) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held with empty result register");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != whsp_pkg::ST_PARSING) |=> (status_r == $past(status_r)))
    else $error("final parse status changed");

  a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.payload_valid) |->
      (phase_r == whsp_pkg::PH_BODY && is_data_r &&
       status_r == whsp_pkg::ST_PARSING))
    else $error("payload byte outside a data chunk body");

  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == whsp_pkg::PH_BODY) |-> (brem_r != 32'd0))
    else $error("chunk body with no bytes left");

endmodule

[tb/wav_header_stream_parser_tb.sv]
// self-checking testbench for the wav header stream parser
`timescale 1ns / 100ps

module wav_header_stream_parser_tb;

  localparam int NO_EOF         = -1;
  localparam int RANDOM_BYTES   = 800;
  localparam int HOLD_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [15:0] MONO  = 16'd1;

  typedef struct packed {
    logic [31:0] v;
    logic [2:0]  n;
    logic        zero_out;
  } field_row_t;

  typedef struct packed {
    whsp_pkg::in_t w;
    logic          zero_out;
  } file_row_t;

  typedef enum int {
    END_DATA_DONE, END_IN_SKIP, END_IN_DATA, END_IN_TAG, END_BAD_LEN, END_EMPTY_CHUNK
  } tail_kind_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  whsp_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  whsp_pkg::out_t out_data;

  file_row_t      wav_file[$];
  whsp_pkg::out_t parsed_words[$];
  int             taken_bytes = 0;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;
  bit             long_hold = 1'b0;

  // parser state mirror
  whsp_pkg::phase_t ph = whsp_pkg::PH_RIFF_TAG;
  int unsigned fld_idx = 0;
  logic [31:0] fld_acc = '0;
  logic [31:0] total_len = '0;
  logic [31:0] remain = '0;
  logic        in_data_chunk = 1'b0;
  logic        flt_q = 1'b0;
  logic [31:0] rate_q = '0;
  logic [15:0] bits_q = '0;
  logic [2:0]  status_q = whsp_pkg::ST_PARSING;

  wav_header_stream_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic whsp_pkg::out_t parse_file_byte(whsp_pkg::in_t w);
    whsp_pkg::out_t r;
    logic [31:0]    v;
    int unsigned    need;
    r = '0;
    if (status_q == whsp_pkg::ST_PARSING) begin
      if (ph == whsp_pkg::PH_BODY) begin
        if (in_data_chunk) begin
          r.payload_valid = 1'b1;
          r.payload_byte = w.file_byte;
        end
        remain = remain - 1;
        if (remain == 0) ph = whsp_pkg::PH_CHUNK_TAG;
      end else begin
        fld_acc = fld_acc | ({24'd0, w.file_byte} << (8 * fld_idx));
        need = (ph == whsp_pkg::PH_FMT_FORMAT || ph == whsp_pkg::PH_FMT_CHAN ||
                ph == whsp_pkg::PH_FMT_ALIGN || ph == whsp_pkg::PH_FMT_BITS) ? 2 : 4;
        if (fld_idx + 1 >= need) begin
          v = fld_acc;
          fld_idx = 0;
          fld_acc = '0;
          case (ph)
            whsp_pkg::PH_RIFF_TAG: begin
              if (v != whsp_pkg::TAG_RIFF) status_q = whsp_pkg::ST_BAD_TAG;
              ph = whsp_pkg::PH_RIFF_LEN;
            end
            whsp_pkg::PH_RIFF_LEN: begin
              total_len = v;
              ph = whsp_pkg::PH_WAVE_TAG;
            end
            whsp_pkg::PH_WAVE_TAG: begin
              if (v != whsp_pkg::TAG_WAVE) status_q = whsp_pkg::ST_BAD_TAG;
              ph = whsp_pkg::PH_FMT_TAG;
            end
            whsp_pkg::PH_FMT_TAG: begin
              if (v != whsp_pkg::TAG_FMT) status_q = whsp_pkg::ST_BAD_TAG;
              ph = whsp_pkg::PH_FMT_SIZE;
            end
            whsp_pkg::PH_FMT_SIZE: begin
              if (total_len < v) status_q = whsp_pkg::ST_CORRUPT;
              ph = whsp_pkg::PH_FMT_FORMAT;
            end
            whsp_pkg::PH_FMT_FORMAT: begin
              if (v[15:0] == whsp_pkg::FMT_PCM) flt_q = 1'b0;
              else if (v[15:0] == whsp_pkg::FMT_FLOAT) flt_q = 1'b1;
              else status_q = whsp_pkg::ST_UNSUPP;
              ph = whsp_pkg::PH_FMT_CHAN;
            end
            whsp_pkg::PH_FMT_CHAN: begin
              if (v[15:0] != MONO) status_q = whsp_pkg::ST_UNSUPP;
              ph = whsp_pkg::PH_FMT_RATE;
            end
            whsp_pkg::PH_FMT_RATE: begin
              rate_q = v;
              ph = whsp_pkg::PH_FMT_BRATE;
            end
            whsp_pkg::PH_FMT_BRATE: ph = whsp_pkg::PH_FMT_ALIGN;
            whsp_pkg::PH_FMT_ALIGN: ph = whsp_pkg::PH_FMT_BITS;
            whsp_pkg::PH_FMT_BITS: begin
              bits_q = v[15:0];
              if (!((!flt_q && bits_q == whsp_pkg::BITS_PCM) ||
                    (flt_q && bits_q == whsp_pkg::BITS_FLT)))
                status_q = whsp_pkg::ST_UNSUPP;
              ph = whsp_pkg::PH_CHUNK_TAG;
            end
            whsp_pkg::PH_CHUNK_LEN: begin
              if (in_data_chunk && v >= total_len) begin
                status_q = whsp_pkg::ST_CORRUPT;
              end else if (v == 0) begin
                ph = whsp_pkg::PH_CHUNK_TAG;
              end else begin
                remain = v;
                ph = whsp_pkg::PH_BODY;
              end
            end
            default: begin
              in_data_chunk = (v == whsp_pkg::TAG_DATA);
              ph = whsp_pkg::PH_CHUNK_LEN;
            end
          endcase
        end else begin
          fld_idx = fld_idx + 1;
        end
      end
      if (status_q == whsp_pkg::ST_PARSING && w.end_of_file) begin
        if (ph == whsp_pkg::PH_CHUNK_TAG && fld_idx == 0) status_q = whsp_pkg::ST_OK;
        else if (ph == whsp_pkg::PH_BODY && !in_data_chunk) status_q = whsp_pkg::ST_OK;
        else status_q = whsp_pkg::ST_TRUNC;
      end
    end
    r.parse_status = status_q;
    r.float_format = flt_q;
    r.rate_hz = rate_q;
    r.sample_bits = bits_q;
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  task automatic push_field(input logic [31:0] v, input int n, input int eof_at,
                            input bit zero_out);
    whsp_pkg::in_t w;
    for (int i = 0; i < n; i++) begin
      w.file_byte = v[8*i +: 8];
      w.end_of_file = (i == eof_at);
      wav_file.push_back({w, zero_out});
    end
  endtask

  task automatic push_body(input int n, input int eof_at);
    for (int i = 0; i < n; i++)
      push_field($urandom(), 1, (i == eof_at) ? 0 : NO_EOF, 1'b0);
  endtask

  // scoreboard: both channels sampled at the rising edge
  always @(posedge clk) begin
    whsp_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (parsed_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, got %h", $time, out_data);
        end else begin
          want = parsed_words.pop_front();
          cmp_field("payload_valid", 32'(want.payload_valid), 32'(out_data.payload_valid));
          cmp_field("payload_byte", 32'(want.payload_byte), 32'(out_data.payload_byte));
          cmp_field("parse_status", 32'(want.parse_status), 32'(out_data.parse_status));
          cmp_field("float_format", 32'(want.float_format), 32'(out_data.float_format));
          cmp_field("rate_hz", want.rate_hz, out_data.rate_hz);
          cmp_field("sample_bits", 32'(want.sample_bits), 32'(out_data.sample_bits));
        end
      end
      if (in_valid && in_ready) begin
        want = parse_file_byte(in_data);
        // leading header bytes: nothing parsed yet, all outputs zero
        if (wav_file[taken_bytes].zero_out) want = '0;
        parsed_words.push_back(want);
        taken_bytes++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL wav_header_stream_parser");
      $finish;
    end
  end

  // receiver, with one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    field_row_t  dir_rows[22];
    logic [31:0] total, fmt_size, fmt_code, rate, bits, tag, len;
    bit          pcm;
    int          dir_len, kind, n;
    tail_kind_t  tail_kind;

    pcm = 1'($urandom_range(0, 1));
    fmt_code = pcm ? {16'd0, whsp_pkg::FMT_PCM} : {16'd0, whsp_pkg::FMT_FLOAT};
    bits = pcm ? {16'd0, whsp_pkg::BITS_PCM} : {16'd0, whsp_pkg::BITS_FLT};
    total = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(32'h1000, 32'hFFFF_FFFE);
    case ($urandom_range(0, 2))
      0: fmt_size = 32'd16;
      1: fmt_size = 32'd0;
      default: fmt_size = total;
    endcase
    case ($urandom_range(0, 2))
      0: rate = 32'd0;
      1: rate = 32'hFFFF_FFFF;
      default: rate = $urandom();
    endcase

    dir_rows = '{
      {whsp_pkg::TAG_RIFF, 3'd4, 1'b1}, {total, 3'd4, 1'b1}, {whsp_pkg::TAG_WAVE, 3'd4, 1'b1},
      {whsp_pkg::TAG_FMT, 3'd4, 1'b1}, {fmt_size, 3'd4, 1'b1},
      {fmt_code, 3'd2, pcm}, {{16'd0, MONO}, 3'd2, pcm}, {rate, 3'd4, 1'b0},
      {$urandom(), 3'd4, 1'b0}, {{16'd0, 16'($urandom())}, 3'd2, 1'b0}, {bits, 3'd2, 1'b0},
      // near-miss data tag with an empty body
      {whsp_pkg::TAG_DATA ^ 32'h1, 3'd4, 1'b0}, {32'd0, 3'd4, 1'b0},
      {whsp_pkg::TAG_DATA, 3'd4, 1'b0}, {32'd2, 3'd4, 1'b0}, {32'h00, 3'd1, 1'b0},
      {32'hFF, 3'd1, 1'b0},
      {whsp_pkg::TAG_DATA, 3'd4, 1'b0}, {32'd0, 3'd4, 1'b0},
      {32'hFFFF_FFFF, 3'd4, 1'b0}, {32'd1, 3'd4, 1'b0}, {32'hA5, 3'd1, 1'b0}
    };
    foreach (dir_rows[i]) push_field(dir_rows[i].v, dir_rows[i].n, NO_EOF, dir_rows[i].zero_out);
    dir_len = wav_file.size();

    // well-formed chunks with random content
    while (wav_file.size() < dir_len + RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        tag = whsp_pkg::TAG_DATA;
        len = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 24);
      end else begin
        case (kind)
          8: tag = ($urandom_range(0, 1)) ? whsp_pkg::TAG_FMT : whsp_pkg::TAG_RIFF;
          default: tag = $urandom();
        endcase
        if (tag == whsp_pkg::TAG_DATA) tag = tag ^ 32'h1;
        len = (kind == 9) ? 32'd0 : $urandom_range(1, 16);
      end
      push_field(tag, 4, NO_EOF, 1'b0);
      push_field(len, 4, NO_EOF, 1'b0);
      push_body(len, NO_EOF);
    end

    // how the file ends
    tail_kind = tail_kind_t'($urandom_range(0, 5));
    tag = $urandom();
    if (tag == whsp_pkg::TAG_DATA) tag = tag ^ 32'h1;
    case (tail_kind)
      END_DATA_DONE: begin
        len = $urandom_range(1, 8);
        push_field(whsp_pkg::TAG_DATA, 4, NO_EOF, 1'b0);
        push_field(len, 4, NO_EOF, 1'b0);
        push_body(len, len - 1);
      end
      END_IN_SKIP: begin
        push_field(tag, 4, NO_EOF, 1'b0);
        push_field($urandom() | 32'h8000_0000, 4, NO_EOF, 1'b0);
        push_body(4, $urandom_range(0, 3));
      end
      END_IN_DATA: begin
        push_field(whsp_pkg::TAG_DATA, 4, NO_EOF, 1'b0);
        push_field(32'd8, 4, NO_EOF, 1'b0);
        push_body(8, $urandom_range(0, 6));
      end
      END_IN_TAG: push_field(tag, 4, $urandom_range(0, 3), 1'b0);
      END_BAD_LEN: begin
        // data length not below the total; eof on the same byte must not win
        push_field(whsp_pkg::TAG_DATA, 4, NO_EOF, 1'b0);
        push_field($urandom_range(0, 1) ? total : 32'hFFFF_FFFF, 4,
                   $urandom_range(0, 1) ? 3 : NO_EOF, 1'b0);
      end
      default: begin
        push_field(tag, 4, NO_EOF, 1'b0);
        push_field(32'd0, 4, 3, 1'b0);
      end
    endcase
    // bytes after the end are consumed with a sticky status
    for (int i = 0; i < 12; i++)
      push_field($urandom(), 1, $urandom_range(0, 1) ? 0 : NO_EOF, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n = wav_file.size();
    for (int i = 0; i < n; i++) begin
      case (i * 4 / n)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (i == n / 8) long_hold = 1'b1;
      if (i == n / 2) begin
        // drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (parsed_words.size() != 0) @(posedge clk);
      end
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= wav_file[i].w;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (parsed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("PASS wav_header_stream_parser");
    else
      $display("FAIL wav_header_stream_parser");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/whsp_pkg.sv
rtl/core/wav_header_stream_parser.sv
tb/wav_header_stream_parser_tb.sv
